// File: hw/rtl/sgm_pkg.sv
// Shared constants, register codes and word types for the Sobel gradient block.
// No dependencies.
`default_nettype none

package sgm_pkg;

  // Default line store depth; also the widest image that can be handled.
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned GRAD_W     = 11;
  localparam int unsigned MAG_W      = 11;
  localparam int unsigned CFG_W_W    = 11;
  localparam int unsigned CFG_H_W    = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_ADDR_W = 1;
  // Wide enough to hold MAX_WIDTH at the top of its range.
  localparam int unsigned WCMP_W     = 13;
  // Squared gradients and their sum.
  localparam int unsigned SQ_W       = 20;
  localparam int unsigned RAD_W      = 21;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(480);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // One window column plus the position flags of its centre.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic             in_image;
    logic             border;
    logic             frame_end;
  } col_t;

  // Side information carried alongside the magnitude computation.
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     in_image;
    logic                     frame_end;
  } meta_t;

endpackage

`default_nettype wire

// File: hw/rtl/sobel_gradient_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// Throughput: one pixel per cycle (one line store read and one write a cycle); an
// output stall holds the whole back end, and the front once the queue is full.
// Reset: counters and window clear at once; the line store is then swept to
// zero across all MAX_WIDTH entries, during which pixels are stalled (config taken).
`default_nettype none

module sobel_gradient_magnitude #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_we_i,
  input  wire logic [sgm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel words in
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sgm_pkg::PIX_W-1:0]      pixel_i,
  // result words out
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [sgm_pkg::MAG_W-1:0]           magnitude_o,
  output logic [sgm_pkg::GRAD_W-1:0]          grad_x_o,
  output logic [sgm_pkg::GRAD_W-1:0]          grad_y_o,
  output logic                                centre_inside_o,
  output logic                                frame_end_o
);

  // Front builds one window column per pixel (two stored rows plus the new
  // pixel) with the centre's position flags; the queue decouples it from the
  // arithmetic so an output stall does not reach the line store at once.
  logic          push, full, pop, empty;
  sgm_pkg::col_t push_col, pop_col;

  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .push_o      (push),
    .push_data_o (push_col),
    .full_i      (full)
  );

  sgm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_col),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_col),
    .empty_o     (empty)
  );

  // Back: window shift, gx/gy, squares, sum, bitwise root, output register.
  sgm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .col_i           (pop_col),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .magnitude_o     (magnitude_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .centre_inside_o (centre_inside_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sgm_fifo.sv
// Short column queue between front and back.
// Depends on sgm_pkg.
`default_nettype none

module sgm_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire sgm_pkg::col_t push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output sgm_pkg::col_t     pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PW = sgm_pkg::FIFO_PTR_W;

  sgm_pkg::col_t mem_q [sgm_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign full_o     = (count_q == (PW+1)'(sgm_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i)      count_q <= count_q + (PW+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("column queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("column queue underflow");

endmodule

`default_nettype wire

// File: hw/rtl/sgm_front.sv
// Front end: config registers, raster counters, line store and column build.
// Depends on sgm_pkg.
`default_nettype none

module sgm_front #(
  parameter int unsigned MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sgm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sgm_pkg::PIX_W-1:0]      pixel_i,
  output logic                                push_o,
  output sgm_pkg::col_t                       push_data_o,
  input  wire logic                           full_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = 2 * sgm_pkg::PIX_W;
  localparam int unsigned WW = sgm_pkg::WCMP_W;

  // config
  logic [sgm_pkg::CFG_W_W-1:0] width_q;
  logic [sgm_pkg::CFG_H_W-1:0] height_q;

  // position of the next pixel
  logic [CW-1:0]             col_q, col_d;
  logic [sgm_pkg::ROW_W-1:0] row_q, row_d;

  // clear sweep after reset
  logic          clr_busy_q;
  logic [CW-1:0] clr_idx_q;

  // stage register between read issue and column push
  logic                       stg_valid_q;
  logic [sgm_pkg::PIX_W-1:0]  stg_pix_q;
  logic [CW-1:0]              stg_addr_q;
  logic                       stg_inside_q, stg_border_q, stg_fend_q;
  logic                       fwd_q;
  logic [LW-1:0]              fwd_word_q;
  logic [LW-1:0]              line_rdata_q;

  // line store: [15:8] row r-2, [7:0] row r-1
  logic [LW-1:0] line_mem [MAX_WIDTH];

  logic          accept, push;
  logic [WW-1:0] w_ext, w_eff, w_last;
  logic [sgm_pkg::ROW_W-1:0] h_last;
  logic          row_end, frame_end, in_image, border;
  logic [LW-1:0] line_word, wr_word;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sgm_pkg::WIDTH_RST;
      height_q <= sgm_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (sgm_pkg::cfg_reg_e'(cfg_addr_i))
        sgm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[sgm_pkg::CFG_W_W-1:0];
        sgm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[sgm_pkg::CFG_H_W-1:0];
      endcase
    end
  end

  // Width 0 counts as 1, oversize saturates; height 0 counts as 1.
  always_comb begin
    w_ext = WW'(width_q);
    if (width_q == '0)               w_eff = WW'(1);
    else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                             w_eff = w_ext;
    w_last = w_eff - WW'(1);
    h_last = (height_q == '0) ? '0 : height_q - sgm_pkg::ROW_W'(1);
  end

  assign row_end   = (WW'(col_q) >= w_last);
  assign frame_end = row_end && (row_q >= h_last);
  assign in_image  = (row_q != '0) && (col_q != '0);
  assign border    = (row_q == sgm_pkg::ROW_W'(1)) || (col_q == CW'(1));

  assign in_stall_o = clr_busy_q || (stg_valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = stg_valid_q && !full_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + sgm_pkg::ROW_W'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + CW'(1);
      if (clr_idx_q == CW'(MAX_WIDTH - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Previous column's write lands on the edge this one is read: forward it.
  assign line_word = fwd_q ? fwd_word_q : line_rdata_q;
  assign wr_word   = {line_word[sgm_pkg::PIX_W-1:0], stg_pix_q};

  assign mem_we    = clr_busy_q || push;
  assign mem_waddr = clr_busy_q ? clr_idx_q : stg_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : wr_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (accept) line_rdata_q <= line_mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (accept) begin
      stg_valid_q <= 1'b1;
    end else if (push) begin
      stg_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_pix_q    <= pixel_i;
      stg_addr_q   <= col_q;
      stg_inside_q <= in_image;
      stg_border_q <= border;
      stg_fend_q   <= frame_end;
      fwd_q        <= push && (stg_addr_q == col_q);
      fwd_word_q   <= wr_word;
    end
  end

  assign push_o                = push;
  assign push_data_o.top       = line_word[LW-1:sgm_pkg::PIX_W];
  assign push_data_o.mid       = line_word[sgm_pkg::PIX_W-1:0];
  assign push_data_o.bot       = stg_pix_q;
  assign push_data_o.in_image  = stg_inside_q;
  assign push_data_o.border    = stg_border_q;
  assign push_data_o.frame_end = stg_fend_q;

  a_stage_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stg_valid_q |-> push) else $error("front stage overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/sgm_sqrt.sv
// Pipelined integer square root, one result bit per stage, side data alongside.
// Depends on sgm_pkg.
`default_nettype none

module sgm_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [sgm_pkg::RAD_W-1:0] radicand_i,
  input  wire sgm_pkg::meta_t            meta_i,
  output logic                           valid_o,
  output logic [sgm_pkg::MAG_W-1:0]      root_o,
  output sgm_pkg::meta_t                 meta_o
);

  localparam int unsigned N  = sgm_pkg::MAG_W;
  localparam int unsigned VW = sgm_pkg::RAD_W;
  localparam int unsigned RW = sgm_pkg::RAD_W + 1;

  logic [VW-1:0]  v_s   [N+1];
  logic [RW-1:0]  res_s [N+1];
  logic           vld_s [N+1];
  sgm_pkg::meta_t meta_s[N+1];

  assign v_s[0]    = radicand_i;
  assign res_s[0]  = '0;
  assign vld_s[0]  = valid_i;
  assign meta_s[0] = meta_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned SH = 2 * (N - 1 - k);
    localparam logic [RW-1:0] BIT = RW'(1) << SH;

    logic [RW-1:0]  trial;
    logic           ge;
    logic [VW-1:0]  v_q;
    logic [RW-1:0]  res_q;
    logic           vld_q;
    sgm_pkg::meta_t meta_q;

    assign trial = res_s[k] + BIT;
    assign ge    = (RW'(v_s[k]) >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q <= 1'b0;
      else if (en_i) vld_q <= vld_s[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q    <= ge ? v_s[k] - trial[VW-1:0] : v_s[k];
        res_q  <= ge ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
        meta_q <= meta_s[k];
      end
    end

    assign v_s[k+1]    = v_q;
    assign res_s[k+1]  = res_q;
    assign vld_s[k+1]  = vld_q;
    assign meta_s[k+1] = meta_q;
  end

  assign valid_o = vld_s[N];
  assign root_o  = res_s[N][sgm_pkg::MAG_W-1:0];
  assign meta_o  = meta_s[N];

endmodule

`default_nettype wire

// File: hw/rtl/sgm_back.sv
// Back end: 3x3 window, Sobel sums, squares, root and output register.
// Depends on sgm_pkg and sgm_sqrt.
`default_nettype none

module sgm_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sgm_pkg::col_t         col_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [sgm_pkg::MAG_W-1:0]  magnitude_o,
  output logic [sgm_pkg::GRAD_W-1:0] grad_x_o,
  output logic [sgm_pkg::GRAD_W-1:0] grad_y_o,
  output logic                       centre_inside_o,
  output logic                       frame_end_o
);

  localparam int unsigned PW = sgm_pkg::PIX_W;
  localparam int unsigned GW = sgm_pkg::GRAD_W;
  localparam int unsigned SW = PW + 2;

  logic en, pop;

  // window: 0..2 column c-2, 3..5 column c-1 (top, mid, bottom)
  logic [PW-1:0] win_q [6];

  logic [SW-1:0]      sum_r, sum_l, sum_b, sum_t;
  logic signed [GW-1:0] gx_d, gy_d;
  logic               calc;

  logic               g_valid_q, s_valid_q, a_valid_q;
  sgm_pkg::meta_t     g_meta_q, s_meta_q, a_meta_q;
  logic signed [2*GW-1:0] px, py;
  logic [sgm_pkg::SQ_W-1:0]  sqx_q, sqy_q;
  logic [sgm_pkg::RAD_W-1:0] rad_q;

  logic                      r_valid;
  logic [sgm_pkg::MAG_W-1:0] r_root;
  sgm_pkg::meta_t            r_meta;

  logic                      out_valid_q;
  logic [sgm_pkg::MAG_W-1:0] mag_q;
  sgm_pkg::meta_t            out_meta_q;

  // Whole pipe moves when the output register is free or being drained.
  assign en    = !out_valid_q || !out_stall_i;
  assign pop   = en && !empty_i;
  assign pop_o = pop;

  assign sum_r = SW'(col_i.top) + {1'b0, col_i.mid, 1'b0} + SW'(col_i.bot);
  assign sum_l = SW'(win_q[0]) + {1'b0, win_q[1], 1'b0} + SW'(win_q[2]);
  assign sum_b = SW'(win_q[2]) + {1'b0, win_q[5], 1'b0} + SW'(col_i.bot);
  assign sum_t = SW'(win_q[0]) + {1'b0, win_q[3], 1'b0} + SW'(col_i.top);
  assign calc  = col_i.in_image && !col_i.border;
  assign gx_d  = calc ? $signed({1'b0, sum_r}) - $signed({1'b0, sum_l}) : '0;
  assign gy_d  = calc ? $signed({1'b0, sum_b}) - $signed({1'b0, sum_t}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (pop) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= col_i.top;
      win_q[4] <= col_i.mid;
      win_q[5] <= col_i.bot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else if (en) begin
      g_valid_q <= pop;
      s_valid_q <= g_valid_q;
      a_valid_q <= s_valid_q;
    end
  end

  assign px = g_meta_q.grad_x * g_meta_q.grad_x;
  assign py = g_meta_q.grad_y * g_meta_q.grad_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_meta_q.grad_x    <= gx_d;
      g_meta_q.grad_y    <= gy_d;
      g_meta_q.in_image  <= col_i.in_image;
      g_meta_q.frame_end <= col_i.frame_end;
      sqx_q    <= px[sgm_pkg::SQ_W-1:0];
      sqy_q    <= py[sgm_pkg::SQ_W-1:0];
      s_meta_q <= g_meta_q;
      rad_q    <= sgm_pkg::RAD_W'(sqx_q) + sgm_pkg::RAD_W'(sqy_q);
      a_meta_q <= s_meta_q;
    end
  end

  sgm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (a_valid_q),
    .radicand_i (rad_q),
    .meta_i     (a_meta_q),
    .valid_o    (r_valid),
    .root_o     (r_root),
    .meta_o     (r_meta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= r_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q      <= r_root;
      out_meta_q <= r_meta;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign grad_x_o        = out_meta_q.grad_x;
  assign grad_y_o        = out_meta_q.grad_y;
  assign centre_inside_o = out_meta_q.in_image;
  assign frame_end_o     = out_meta_q.frame_end;

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_valid_q && !g_meta_q.in_image |-> g_meta_q.grad_x == '0 && g_meta_q.grad_y == '0)
    else $error("gradient set for a centre outside the image");

  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && r_meta.grad_x == '0 && r_meta.grad_y == '0 |-> r_root == '0)
    else $error("non-zero magnitude for zero gradients");

endmodule

`default_nettype wire
